FILE: design/sqb_pkg.sv
// Shared types and constants for the sprite quad batcher.
package sqb_pkg;
	localparam int CordicSteps = 16;
	localparam logic signed [33:0] CordicStart = 34'sd652032874;
	localparam logic [10:0] QuadLimitReset = 11'd1024;
	localparam logic [4:0] SlotCapReset = 5'd16;
	localparam logic [0:0] RegQuadLimit = 1'b0;
	localparam logic [0:0] RegSlotCap = 1'b1;
	localparam logic ActSprite = 1'b0;
	localparam logic ActEof = 1'b1;
	localparam logic KindVertex = 1'b0;
	localparam logic KindDraw = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] texture_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [23:0] half_width;
		logic [23:0] half_height;
		logic [23:0] scale;
		logic [15:0] angle;
	} sprite_t;

	typedef struct packed {
		logic        kind;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic        tex_u;
		logic        tex_v;
		logic [3:0]  slot;
		logic [11:0] vertex_index;
		logic [10:0] quads_in_draw;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        cfg_idx;
		logic [10:0] cfg_data;
	} cfg_t;

	// Classified command from front to back.
	typedef struct packed {
		logic        draw;
		logic        verts;
		logic [10:0] draw_quads;
		logic [3:0]  slot;
		logic [11:0] base_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [23:0] half_width;
		logic [23:0] half_height;
		logic [23:0] scale;
		logic [15:0] angle;
	} cmd_t;

	function automatic logic [15:0] atan_turn(input logic [3:0] i);
		case (i)
			4'd0: atan_turn = 16'd8192;
			4'd1: atan_turn = 16'd4836;
			4'd2: atan_turn = 16'd2555;
			4'd3: atan_turn = 16'd1297;
			4'd4: atan_turn = 16'd651;
			4'd5: atan_turn = 16'd326;
			4'd6: atan_turn = 16'd163;
			4'd7: atan_turn = 16'd81;
			4'd8: atan_turn = 16'd41;
			4'd9: atan_turn = 16'd20;
			4'd10: atan_turn = 16'd10;
			4'd11: atan_turn = 16'd5;
			4'd12: atan_turn = 16'd3;
			4'd13: atan_turn = 16'd1;
			4'd14: atan_turn = 16'd1;
			default: atan_turn = 16'd0;
		endcase
	endfunction
endpackage

FILE: design/sqb_if.sv
// Valid/ready channel interfaces carrying sprites, results and config writes.
interface sqb_sprite_if;
	import sqb_pkg::*;
	logic valid;
	logic ready;
	sprite_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sqb_result_if;
	import sqb_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sqb_cfg_if;
	import sqb_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/sqb_front.sv
// Front end: slot lookup, batch bookkeeping and command classification.
module sqb_front
	import sqb_pkg::*;
#(
	parameter int MAX_SLOTS = 16,
	parameter int MAX_QUADS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	sqb_sprite_if.sink sprite,
	sqb_cfg_if.sink cfg,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_ready
);
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int UW = $clog2(MAX_SLOTS + 1);
	localparam int QW = $clog2(MAX_QUADS + 1);

	typedef enum logic [1:0] {IDLE, SEARCH, ISSUE} fstate_t;
	fstate_t state_q;

	logic [15:0] tags_q [MAX_SLOTS];
	logic [UW-1:0] used_q;
	logic [QW-1:0] held_q;
	logic [10:0] limit_q;
	logic [4:0] cap_q;
	sprite_t spr_q;
	logic [UW-1:0] idx_q;
	logic found_q;
	logic [SW-1:0] hit_q;
	logic [QW-1:0] limit_c;
	logic [UW-1:0] cap_c;
	logic flush;
	logic [SW-1:0] new_slot;

	always_comb begin
		if (limit_q == 11'd0)
			limit_c = QW'(1);
		else if (32'(limit_q) > MAX_QUADS)
			limit_c = QW'(MAX_QUADS);
		else
			limit_c = QW'(limit_q);
		if (cap_q == 5'd0)
			cap_c = UW'(1);
		else if (32'(cap_q) > MAX_SLOTS)
			cap_c = UW'(MAX_SLOTS);
		else
			cap_c = UW'(cap_q);
	end

	assign flush = (held_q >= limit_c) || (!found_q && used_q >= cap_c);
	assign new_slot = flush ? SW'(0) : SW'(used_q);
	assign cfg.ready = 1'b1;
	assign sprite.ready = (state_q == IDLE);
	assign cmd_valid = (state_q == ISSUE);

	always_comb begin
		cmd = '0;
		cmd.pos_x = spr_q.pos_x;
		cmd.pos_y = spr_q.pos_y;
		cmd.pos_z = spr_q.pos_z;
		cmd.half_width = spr_q.half_width;
		cmd.half_height = spr_q.half_height;
		cmd.scale = spr_q.scale;
		cmd.angle = spr_q.angle;
		cmd.draw_quads = 11'(held_q);
		if (spr_q.action == ActEof) begin
			cmd.draw = 1'b1;
		end else begin
			cmd.verts = 1'b1;
			cmd.draw = flush;
			cmd.slot = 4'((!flush && found_q) ? hit_q : new_slot);
			cmd.base_index = flush ? 12'd0 : 12'({held_q, 2'b00});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEARCH && idx_q < used_q && !found_q &&
				tags_q[SW'(idx_q)] == spr_q.texture_id)
			hit_q <= SW'(idx_q);
		if (state_q == ISSUE && cmd_ready && spr_q.action == ActSprite &&
				(flush || !found_q))
			tags_q[new_slot] <= spr_q.texture_id;
		if (sprite.valid && state_q == IDLE)
			spr_q <= sprite.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			used_q <= '0;
			held_q <= '0;
			limit_q <= QuadLimitReset;
			cap_q <= SlotCapReset;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.data.cfg_idx == RegQuadLimit)
					limit_q <= cfg.data.cfg_data;
				else
					cap_q <= cfg.data.cfg_data[4:0];
			end
			case (state_q)
				IDLE: begin
					if (sprite.valid) begin
						idx_q <= '0;
						found_q <= 1'b0;
						if (sprite.data.action == ActEof)
							state_q <= (held_q == '0) ? IDLE : ISSUE;
						else
							state_q <= SEARCH;
					end
				end
				SEARCH: begin
					if (idx_q >= used_q || found_q) begin
						state_q <= ISSUE;
					end else begin
						if (tags_q[SW'(idx_q)] == spr_q.texture_id)
							found_q <= 1'b1;
						idx_q <= idx_q + UW'(1);
					end
				end
				ISSUE: begin
					if (cmd_ready) begin
						state_q <= IDLE;
						if (spr_q.action == ActEof) begin
							used_q <= '0;
							held_q <= '0;
						end else begin
							held_q <= (flush ? QW'(0) : held_q) + QW'(1);
							if (flush)
								used_q <= UW'(1);
							else if (!found_q)
								used_q <= used_q + UW'(1);
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_SLOTS)) else $error("slot count overflow");
	a_held_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= QW'(MAX_QUADS)) else $error("quad count overflow");
	a_cmd_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.draw || cmd.verts)) else $error("empty command");
endmodule

FILE: design/sqb_back.sv
// Back end: scale, CORDIC rotation and emission of draw and vertex beats.
module sqb_back
	import sqb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_ready,
	sqb_result_if.source result
);
	typedef enum logic [2:0] {IDLE, SCALE, ROT, MUL, EMIT} bstate_t;
	bstate_t state_q;
	cmd_t c_q;
	logic pend_draw_q;
	logic [3:0] step_q;
	logic [1:0] corner_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [17:0] z_q;
	logic neg_q;
	logic signed [32:0] w_q, h_q;
	logic signed [65:0] xc_q, ys_q, xs_q, yc_q;
	logic out_valid_q;
	result_t out_q;

	logic [47:0] pw, ph;
	logic [31:0] pwr, phr;
	logic signed [17:0] za;
	logic signed [33:0] sxx, syy;
	logic signed [32:0] xo, yo;
	logic signed [65:0] rxs, rys;
	logic signed [35:0] rx, ry;
	result_t beat_c;

	assign pw = c_q.half_width * c_q.scale + 48'h8000;
	assign ph = c_q.half_height * c_q.scale + 48'h8000;
	assign pwr = (pw[47:16] > 32'h7FFFFFFF) ? 32'h7FFFFFFF : pw[47:16];
	assign phr = (ph[47:16] > 32'h7FFFFFFF) ? 32'h7FFFFFFF : ph[47:16];
	assign za = 18'(signed'(c_q.angle));
	assign sxx = cx_q >>> step_q;
	assign syy = cy_q >>> step_q;
	assign xo = (corner_q[1]) ? w_q : -w_q;
	assign yo = (corner_q == 2'd1 || corner_q == 2'd2) ? h_q : -h_q;
	assign rxs = xc_q - ys_q + (66'sd1 <<< 29);
	assign rys = xs_q + yc_q + (66'sd1 <<< 29);
	assign rx = rxs[65:30];
	assign ry = rys[65:30];
	assign cmd_ready = (state_q == IDLE);
	assign result.valid = out_valid_q;
	assign result.data = out_q;

	always_comb begin
		beat_c = '0;
		if (pend_draw_q) begin
			beat_c.kind = KindDraw;
			beat_c.quads_in_draw = c_q.draw_quads;
			beat_c.last = !c_q.verts;
		end else begin
			beat_c.kind = KindVertex;
			beat_c.vert_x = c_q.pos_x + 32'(rx);
			beat_c.vert_y = c_q.pos_y + 32'(ry);
			beat_c.vert_z = c_q.pos_z;
			beat_c.tex_u = corner_q[1];
			beat_c.tex_v = (corner_q == 2'd1 || corner_q == 2'd2);
			beat_c.slot = c_q.slot;
			beat_c.vertex_index = c_q.base_index + 12'(corner_q);
			beat_c.last = (corner_q == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && cmd_valid)
			c_q <= cmd;
		if (state_q == SCALE) begin
			w_q <= 33'(pwr);
			h_q <= 33'(phr);
		end
		if (state_q == MUL) begin
			xc_q <= 66'(xo) * 66'(neg_q ? -cx_q : cx_q);
			ys_q <= 66'(yo) * 66'(neg_q ? -cy_q : cy_q);
			xs_q <= 66'(xo) * 66'(neg_q ? -cy_q : cy_q);
			yc_q <= 66'(yo) * 66'(neg_q ? -cx_q : cx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
			pend_draw_q <= 1'b0;
			step_q <= '0;
			corner_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			z_q <= '0;
			neg_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && result.ready && state_q != EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (cmd_valid) begin
						pend_draw_q <= cmd.draw;
						state_q <= cmd.verts ? SCALE : EMIT;
					end
				end
				SCALE: begin
					step_q <= '0;
					corner_q <= '0;
					cx_q <= CordicStart;
					cy_q <= '0;
					if (za > 18'sd16384) begin
						z_q <= za - 18'sd32768;
						neg_q <= 1'b1;
					end else if (za < -18'sd16384) begin
						z_q <= za + 18'sd32768;
						neg_q <= 1'b1;
					end else begin
						z_q <= za;
						neg_q <= 1'b0;
					end
					state_q <= ROT;
				end
				ROT: begin
					if (z_q >= 0) begin
						cx_q <= cx_q - syy;
						cy_q <= cy_q + sxx;
						z_q <= z_q - 18'(atan_turn(step_q));
					end else begin
						cx_q <= cx_q + syy;
						cy_q <= cy_q - sxx;
						z_q <= z_q + 18'(atan_turn(step_q));
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'(CordicSteps - 1))
						state_q <= MUL;
				end
				MUL: state_q <= EMIT;
				EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_q <= beat_c;
						if (pend_draw_q) begin
							pend_draw_q <= 1'b0;
							if (!c_q.verts)
								state_q <= IDLE;
						end else begin
							corner_q <= corner_q + 2'd1;
							state_q <= (corner_q == 2'd3) ? IDLE : MUL;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> $stable(out_q)) else $error("beat changed");
	a_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KindVertex) |-> out_q.quads_in_draw == '0)
		else $error("vertex carries count");
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> state_q != IDLE) else $error("command lost");
endmodule

FILE: design/sprite_quad_batcher.sv
// Sprite quad batcher top level.
// Each sprite is accepted, its texture is looked up among the slots in use, and
// it is rotated in 16 CORDIC iterations of a shared rotator; each vertex then goes
// through the product stage and the output register, and one more beat is sent
// when a draw is forced. The front end may look up the next sprite while
// the back end rotates. Config writes are always accepted.
module sprite_quad_batcher
	import sqb_pkg::*;
#(
	parameter int MAX_SLOTS = 16,
	parameter int MAX_QUADS = 1024
) (
	input logic clk,
	input logic arst_n,
	sqb_sprite_if.sink sprite,
	sqb_cfg_if.sink cfg,
	sqb_result_if.source result
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	sqb_front #(.MAX_SLOTS(MAX_SLOTS), .MAX_QUADS(MAX_QUADS)) u_front (
		.clk(clk), .arst_n(arst_n), .sprite(sprite), .cfg(cfg),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	sqb_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_ready(cmd_ready), .result(result)
	);
endmodule

FILE: sim/sprite_quad_batcher_test.sv
// Self-checking testbench for the sprite quad batcher: batching, slot caching and corners.
module sprite_quad_batcher_test;
	import sqb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 600000;
	localparam int SettleCycles = 80;

	class quad_scoreboard;
		result_t expected_beats[$];
		logic [15:0] tags[16];
		int unsigned used, held, limit_reg, slot_cap;
		int errors, beats_checked, draws_seen;
		longint turn_step[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
			41, 20, 10, 5, 3, 1, 1, 0};

		function new();
			used = 0;
			held = 0;
			limit_reg = 1024;
			slot_cap = 16;
		endfunction

		function void write_reg(logic idx, logic [10:0] value);
			if (idx == RegQuadLimit)
				limit_reg = value;
			else
				slot_cap = value[4:0];
		endfunction

		function longint half_size(logic [23:0] half, logic [23:0] scl);
			longint p;
			p = (longint'(half) * longint'(scl) + 32768) >> 16;
			if (p > 64'h7FFFFFFF)
				p = 64'h7FFFFFFF;
			return p;
		endfunction

		function void rotation(logic [15:0] ang, output longint c, output longint s);
			longint z, x, y, nx;
			bit flip;
			z = longint'($signed(ang));
			flip = 0;
			if (z > 16384) begin
				z -= 32768;
				flip = 1;
			end else if (z < -16384) begin
				z += 32768;
				flip = 1;
			end
			x = 652032874;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= turn_step[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += turn_step[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void push_draw(bit is_last);
			result_t r;
			r = '0;
			r.kind = KindDraw;
			r.quads_in_draw = held[10:0];
			r.last = is_last;
			expected_beats = {expected_beats, r};
			draws_seen++;
			used = 0;
			held = 0;
		endfunction

		function void note_sprite(sprite_t sp);
			int unsigned lim, cap, slot;
			bit hit;
			longint w, h, c, s, x, y, rx, ry;
			result_t r;
			lim = (limit_reg < 1) ? 1 : (limit_reg > 1024) ? 1024 : limit_reg;
			cap = (slot_cap < 1) ? 1 : (slot_cap > 16) ? 16 : slot_cap;
			if (sp.action == ActEof) begin
				if (held != 0)
					push_draw(1);
				return;
			end
			hit = 0;
			slot = 0;
			for (int i = 0; i < used; i++)
				if (!hit && tags[i] == sp.texture_id) begin
					hit = 1;
					slot = i;
				end
			if (held >= lim || (!hit && used >= cap)) begin
				push_draw(0);
				hit = 0;
			end
			if (!hit) begin
				slot = used;
				tags[slot] = sp.texture_id;
				used++;
			end
			w = half_size(sp.half_width, sp.scale);
			h = half_size(sp.half_height, sp.scale);
			rotation(sp.angle, c, s);
			for (int k = 0; k < 4; k++) begin
				x = (k >= 2) ? w : -w;
				y = (k == 1 || k == 2) ? h : -h;
				rx = (x * c - y * s + (longint'(1) << 29)) >>> 30;
				ry = (x * s + y * c + (longint'(1) << 29)) >>> 30;
				r = '0;
				r.kind = KindVertex;
				r.vert_x = 32'(longint'(sp.pos_x) + rx);
				r.vert_y = 32'(longint'(sp.pos_y) + ry);
				r.vert_z = sp.pos_z;
				r.tex_u = (k >= 2);
				r.tex_v = (k == 1 || k == 2);
				r.slot = slot[3:0];
				r.vertex_index = 12'(held * 4 + k);
				r.last = (k == 3);
				expected_beats = {expected_beats, r};
			end
			held++;
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		task check_beat(result_t got);
			result_t want;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				report("unexpected beat", longint'(got.kind), 0);
				return;
			end
			want = expected_beats.pop_front();
			if (got.kind !== want.kind) report("kind", got.kind, want.kind);
			if (got.vert_x !== want.vert_x) report("vert_x", got.vert_x, want.vert_x);
			if (got.vert_y !== want.vert_y) report("vert_y", got.vert_y, want.vert_y);
			if (got.vert_z !== want.vert_z) report("vert_z", got.vert_z, want.vert_z);
			if (got.tex_u !== want.tex_u) report("tex_u", got.tex_u, want.tex_u);
			if (got.tex_v !== want.tex_v) report("tex_v", got.tex_v, want.tex_v);
			if (got.slot !== want.slot) report("slot", got.slot, want.slot);
			if (got.vertex_index !== want.vertex_index)
				report("vertex_index", got.vertex_index, want.vertex_index);
			if (got.quads_in_draw !== want.quads_in_draw)
				report("quads_in_draw", got.quads_in_draw, want.quads_in_draw);
			if (got.last !== want.last) report("last", got.last, want.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	int cycles;
	int items_sent;
	quad_scoreboard board;

	sqb_sprite_if spr();
	sqb_cfg_if cfg();
	sqb_result_if res();

	sprite_quad_batcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.sprite(spr),
		.cfg(cfg),
		.result(res)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		spr.valid = 0;
		spr.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk)
		res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);

	always @(posedge clk)
		if (arst_n && res.valid && res.ready)
			board.check_beat(res.data);

	task automatic send_sprite(input sprite_t sp);
		while (!calm && $urandom_range(99) < 15) begin
			spr.valid <= 0;
			@(negedge clk);
		end
		spr.valid <= 1;
		spr.data <= sp;
		do @(posedge clk); while (!spr.ready);
		board.note_sprite(sp);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] value);
		spr.valid <= 0;
		while (board.expected_beats.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg.valid <= 1;
		cfg.data <= '{cfg_idx: idx, cfg_data: value};
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, value);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	function automatic sprite_t random_sprite(int tex_pool);
		sprite_t sp;
		sp.action = ($urandom_range(99) < 6) ? ActEof : ActSprite;
		sp.texture_id = ($urandom_range(99) < 10) ? 16'($urandom) :
			16'($urandom_range(tex_pool));
		sp.pos_x = $urandom;
		sp.pos_y = $urandom;
		sp.pos_z = $urandom;
		if ($urandom_range(99) < 20) begin
			sp.half_width = 24'($urandom);
			sp.half_height = 24'($urandom);
			sp.scale = 24'($urandom);
		end else begin
			sp.half_width = 24'($urandom_range(24'hFFFFF));
			sp.half_height = 24'($urandom_range(24'hFFFFF));
			sp.scale = 24'($urandom_range(24'h3FFFF));
		end
		sp.angle = 16'($urandom);
		return sp;
	endfunction

	function automatic sprite_t plain_sprite(logic [15:0] tex, logic [15:0] ang);
		sprite_t sp;
		sp = '0;
		sp.action = ActSprite;
		sp.texture_id = tex;
		sp.pos_x = 32'sh0010_0000;
		sp.pos_y = -32'sh0020_0000;
		sp.pos_z = 32'sh0000_8000;
		sp.half_width = 24'h01_0000;
		sp.half_height = 24'h00_8000;
		sp.scale = 24'h01_0000;
		sp.angle = ang;
		return sp;
	endfunction

	logic [10:0] limit_plan[6] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd5, 11'd3};
	logic [10:0] cap_plan[6] = '{11'd16, 11'd1, 11'd0, 11'd31, 11'd3, 11'd16};

	initial begin
		sprite_t sp;
		board = new();
		calm = 0;
		cycles = 0;
		items_sent = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty end of frame, angle boundaries, field extremes
		sp = plain_sprite(16'h0, 16'h0);
		sp.action = ActEof;
		send_sprite(sp);
		send_sprite(plain_sprite(16'h0000, 16'h0000));
		send_sprite(plain_sprite(16'hFFFF, 16'h4000));
		send_sprite(plain_sprite(16'h0000, 16'h4001));
		send_sprite(plain_sprite(16'h1234, 16'h8000));
		send_sprite(plain_sprite(16'hFFFF, 16'hC000));
		send_sprite(plain_sprite(16'h5555, 16'hBFFF));
		send_sprite(plain_sprite(16'hAAAA, 16'hFFFF));
		send_sprite(plain_sprite(16'h0001, 16'h7FFF));
		sp = plain_sprite(16'h0002, 16'h2000);
		sp.half_width = 24'hFFFFFF;
		sp.half_height = 24'hFFFFFF;
		sp.scale = 24'hFFFFFF;
		sp.pos_x = 32'sh7FFF_FFFF;
		sp.pos_y = -32'sh8000_0000;
		sp.pos_z = -32'sh8000_0000;
		send_sprite(sp);
		sp.pos_x = -32'sh8000_0000;
		sp.pos_y = 32'sh7FFF_FFFF;
		sp.pos_z = 32'sh7FFF_FFFF;
		sp.angle = 16'hA000;
		send_sprite(sp);
		sp = plain_sprite(16'h0003, 16'h1000);
		sp.half_width = 0;
		sp.half_height = 0;
		send_sprite(sp);
		sp.scale = 0;
		sp.half_width = 24'hFFFFFF;
		send_sprite(sp);
		sp.action = ActEof;
		send_sprite(sp);
		send_sprite(sp);

		for (int phase = 0; phase < 6; phase++) begin
			write_reg(RegQuadLimit, limit_plan[phase]);
			write_reg(RegSlotCap, cap_plan[phase]);
			for (int n = 0; n < 78; n++) begin
				calm = (phase == 3);
				send_sprite(random_sprite((phase % 2) ? 6 : 24));
			end
			calm = 0;
		end
		spr.valid <= 0;

		while (board.expected_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		$display("%0d sprites sent, %0d beats checked, %0d draws, 6 register settings",
			items_sent, board.beats_checked, board.draws_seen);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
